FILE: rtl/kdr_pkg.sv
// Shared types and constants for the key debounce, auto-repeat and long-press unit.
package kdr_pkg;

	localparam int unsigned KEY_COUNT = 7;
	localparam int unsigned DIR_COUNT = 4;
	localparam int unsigned KEY_UP = 2;
	localparam int unsigned KEY_CENTER = 6;

	// Bit positions in the pending event word.
	localparam int unsigned EV_WIDTH = 12;
	localparam int unsigned EV_PRESS_COUNT = 6;
	localparam int unsigned EV_REPEAT_SHIFT = 6;
	localparam int unsigned EV_SHORT_BIT = 10;
	localparam int unsigned EV_LONG_BIT = 11;

	localparam logic [15:0] HELD_MAX = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [7:0] REG_DEBOUNCE_COUNT = 8'd0;
	localparam logic [7:0] REG_REPEAT_DELAY = 8'd1;
	localparam logic [7:0] REG_REPEAT_PERIOD = 8'd2;
	localparam logic [7:0] REG_LONG_PRESS_TICKS = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] DEBOUNCE_RESET = 8'd3;
	localparam logic [15:0] REPEAT_DELAY_RESET = 16'd50;
	localparam logic [15:0] REPEAT_PERIOD_RESET = 16'd10;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd100;

	// Request function codes.
	typedef enum logic {
		FUNC_SCAN = 1'b0,
		FUNC_READ = 1'b1
	} func_t;

	// Status of one debounced key for the current scan.
	typedef struct packed {
		logic stable;      // debounced state before the scan
		logic stable_nxt;  // debounced state after the scan
		logic changed;     // debounced state changes on this scan
	} key_upd_t;

endpackage

FILE: rtl/key_debounce_repeat_longpress_unit.sv
// A request passes through the input register and then the result register on its way to the outputs.
// Throughput: one request per cycle; the input register and the result register
// each move on once the result register is free or is being emptied.
// The configuration port is always ready. Reset clears every key to released,
// the events to none and the registers to their documented reset values.
module key_debounce_repeat_longpress_unit import kdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [6:0]  key_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  press_events,
	output logic [3:0]  repeat_events,
	output logic        center_short,
	output logic        center_long,
	output logic [6:0]  stable_keys,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  db_count_q;
	logic [15:0] rep_delay_q;
	logic [15:0] rep_period_q;
	logic [15:0] long_ticks_q;

	logic        valid_s1;
	func_t       func_s1;
	logic [6:0]  levels_s1;

	logic        out_valid_q;
	logic [5:0]  press_q;
	logic [3:0]  repeat_q;
	logic        short_q;
	logic        long_q;
	logic [6:0]  stable_out_q;

	logic [EV_WIDTH-1:0] pending_q;
	logic [15:0] cd_q [DIR_COUNT];
	logic [15:0] held_q;
	logic        long_sent_q;

	logic        adv;
	logic        scan_en;
	key_upd_t    upd [KEY_COUNT];
	logic [6:0]  stable_cur;
	logic [6:0]  stable_nxt;

	logic [EV_WIDTH-1:0] pend_scan;
	logic [15:0] cd_nxt [DIR_COUNT];
	logic [15:0] held_nxt;
	logic        long_sent_nxt;

	// Handshakes.
	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign scan_en = adv && (func_s1 == FUNC_SCAN);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_count_q <= DEBOUNCE_RESET;
			rep_delay_q <= REPEAT_DELAY_RESET;
			rep_period_q <= REPEAT_PERIOD_RESET;
			long_ticks_q <= LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_COUNT:   db_count_q <= cfg_data[7:0];
				REG_REPEAT_DELAY:     rep_delay_q <= cfg_data;
				REG_REPEAT_PERIOD:    rep_period_q <= cfg_data;
				REG_LONG_PRESS_TICKS: long_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func_t'(func);
			levels_s1 <= key_levels;
		end
	end

	// One debounce filter per key.
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
		kdr_debounce u_debounce (
			.clk            (clk),
			.arst_n         (arst_n),
			.scan_en        (scan_en),
			.level          (levels_s1[k]),
			.debounce_count (db_count_q),
			.upd            (upd[k])
		);
		assign stable_cur[k] = upd[k].stable;
		assign stable_nxt[k] = upd[k].stable_nxt;
	end

	// Press events, repeat countdowns and the center hold counter for one scan.
	always_comb begin
		logic [15:0] cd_dec;
		logic [15:0] held_inc;
		logic        ls_mid;
		pend_scan = pending_q;
		for (int k = 0; k < EV_PRESS_COUNT; k++) begin
			if (upd[k].changed && upd[k].stable_nxt) begin
				pend_scan[k] = 1'b1;
			end
		end
		for (int d = 0; d < DIR_COUNT; d++) begin
			cd_nxt[d] = cd_q[d];
			cd_dec = (cd_q[d] != 16'd0) ? cd_q[d] - 16'd1 : cd_q[d];
			if (upd[KEY_UP + d].changed) begin
				cd_nxt[d] = upd[KEY_UP + d].stable_nxt ? rep_delay_q : 16'd0;
			end else if (upd[KEY_UP + d].stable_nxt) begin
				if (cd_dec == 16'd0) begin
					pend_scan[EV_REPEAT_SHIFT + d] = 1'b1;
					cd_nxt[d] = rep_period_q;
				end else begin
					cd_nxt[d] = cd_dec;
				end
			end
		end
		// Center: short event on release unless the long event already went out.
		held_nxt = held_q;
		ls_mid = long_sent_q;
		if (upd[KEY_CENTER].changed) begin
			if (!upd[KEY_CENTER].stable_nxt && !long_sent_q) begin
				pend_scan[EV_SHORT_BIT] = 1'b1;
			end
			held_nxt = 16'd0;
			ls_mid = 1'b0;
		end
		long_sent_nxt = ls_mid;
		held_inc = (held_nxt < HELD_MAX) ? held_nxt + 16'd1 : held_nxt;
		if (upd[KEY_CENTER].stable_nxt && !ls_mid) begin
			held_nxt = held_inc;
			if (held_inc >= long_ticks_q) begin
				long_sent_nxt = 1'b1;
				pend_scan[EV_LONG_BIT] = 1'b1;
			end
		end
	end

	// Event state and repeat timers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			held_q <= '0;
			long_sent_q <= 1'b0;
			for (int d = 0; d < DIR_COUNT; d++) begin
				cd_q[d] <= '0;
			end
		end else if (adv) begin
			if (func_s1 == FUNC_READ) begin
				pending_q <= '0;
			end else begin
				pending_q <= pend_scan;
				held_q <= held_nxt;
				long_sent_q <= long_sent_nxt;
				for (int d = 0; d < DIR_COUNT; d++) begin
					cd_q[d] <= cd_nxt[d];
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (func_s1 == FUNC_READ) begin
				press_q <= pending_q[EV_PRESS_COUNT-1:0];
				repeat_q <= pending_q[EV_REPEAT_SHIFT +: DIR_COUNT];
				short_q <= pending_q[EV_SHORT_BIT];
				long_q <= pending_q[EV_LONG_BIT];
				stable_out_q <= stable_cur;
			end else begin
				press_q <= pend_scan[EV_PRESS_COUNT-1:0];
				repeat_q <= pend_scan[EV_REPEAT_SHIFT +: DIR_COUNT];
				short_q <= pend_scan[EV_SHORT_BIT];
				long_q <= pend_scan[EV_LONG_BIT];
				stable_out_q <= stable_nxt;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign press_events = press_q;
	assign repeat_events = repeat_q;
	assign center_short = short_q;
	assign center_long = long_q;
	assign stable_keys = stable_out_q;

	// A read request leaves no event pending.
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && func_s1 == FUNC_READ) |=> (pending_q == '0))
		else $error("pending events survived a read request");

	// The long event is only marked sent while the center key is held.
	a_long_sent_held: assert property (@(posedge clk) disable iff (!arst_n)
		long_sent_q |-> stable_cur[KEY_CENTER])
		else $error("long press marked sent with center released");

	// A released direction key has no running repeat timer.
	a_cd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(stable_cur[KEY_UP] || cd_q[0] == 16'd0) &&
		(stable_cur[KEY_UP + 1] || cd_q[1] == 16'd0) &&
		(stable_cur[KEY_UP + 2] || cd_q[2] == 16'd0) &&
		(stable_cur[KEY_UP + 3] || cd_q[3] == 16'd0))
		else $error("repeat timer running on a released key");

endmodule

FILE: rtl/kdr_debounce.sv
// Debounce filter for one active-low key.
module kdr_debounce import kdr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_en,
	input  logic       level,
	input  logic [7:0] debounce_count,
	output key_upd_t   upd
);

	logic       cand_q;
	logic       stable_q;
	logic [7:0] cnt_q;
	logic       pressed;
	logic       cand_nxt;
	logic [7:0] cnt_nxt;
	logic       changed;

	assign pressed = ~level;

	// Count equal samples in a row, restarting on a new candidate level.
	always_comb begin
		if (pressed == cand_q) begin
			cand_nxt = cand_q;
			cnt_nxt = (cnt_q < debounce_count) ? cnt_q + 8'd1 : cnt_q;
		end else begin
			cand_nxt = pressed;
			cnt_nxt = 8'd1;
		end
		changed = (cnt_nxt >= debounce_count) && (stable_q != cand_nxt);
	end

	assign upd.stable = stable_q;
	assign upd.changed = changed;
	assign upd.stable_nxt = changed ? cand_nxt : stable_q;

	// Filter state advances on every scan request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
			stable_q <= 1'b0;
			cnt_q <= DEBOUNCE_RESET;
		end else if (scan_en) begin
			cand_q <= cand_nxt;
			stable_q <= upd.stable_nxt;
			cnt_q <= cnt_nxt;
		end
	end

endmodule
